// ===== rtl/core/thermal_vss_zone_selector_top_assert.svh =====
// Assertion macros for the thermal VSS zone selector.
// Used by thermal_vss_zone_selector_top.sv; no other dependencies.
`ifndef THERMAL_VSS_ZONE_SELECTOR_TOP_ASSERT_SVH
`define THERMAL_VSS_ZONE_SELECTOR_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TVZS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tvzs: implication check failed");

// next-cycle implication, disabled in reset
`define TVZS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tvzs: next-cycle check failed");

`endif

// ===== rtl/core/tvzs_pkg.sv =====
// Shared types and constants for the thermal VSS zone selector.
// No dependencies.
package tvzs_pkg;

    localparam int TEMP_W  = 18;
    localparam int BL_W    = 12;
    localparam int ZONE_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 18;

    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [BL_W-1:0]          t_bl;
    typedef logic [ZONE_W-1:0]        t_zone;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]    t_cfg_data;

    localparam t_zone ZONE_NONE = 2'd0;
    localparam t_zone ZONE_COLD = 2'd1;
    localparam t_zone ZONE_MID  = 2'd2;
    localparam t_zone ZONE_HOT  = 2'd3;

    localparam t_cfg_idx REG_COLD_LIMIT = 2'd0;
    localparam t_cfg_idx REG_HOT_LIMIT  = 2'd1;
    localparam t_cfg_idx REG_BL_LOW     = 2'd2;
    localparam t_cfg_idx REG_BL_HIGH    = 2'd3;

    localparam t_temp RST_COLD_LIMIT = 18'sd0;
    localparam t_temp RST_HOT_LIMIT  = 18'sd10000;
    localparam t_bl   RST_BL_LOW     = 12'd3000;
    localparam t_bl   RST_BL_HIGH    = 12'd3975;

    typedef struct packed {
        t_temp cold_limit;
        t_temp hot_limit;
        t_bl   bl_low;
        t_bl   bl_high;
    } t_cfg;

    typedef struct packed {
        t_temp temperature;
        t_bl   backlight_level;
        logic  panel_off;
    } t_sample;

    typedef struct packed {
        t_zone command;
        t_zone zone;
        logic  descending;
    } t_result;

endpackage

// ===== rtl/core/tvzs_ifs.sv =====
// Request and result channel interfaces for the zone selector.
// Depends on tvzs_pkg.
interface tvzs_req_if import tvzs_pkg::*; ();
    logic  valid;
    logic  ready;
    t_temp temperature;
    t_bl   backlight_level;
    logic  panel_off;

    modport source (output valid, output temperature, output backlight_level,
                    output panel_off, input ready);
    modport sink   (input valid, input temperature, input backlight_level,
                    input panel_off, output ready);
endinterface

interface tvzs_rsp_if import tvzs_pkg::*; ();
    logic  valid;
    logic  ready;
    t_zone command;
    t_zone zone;
    logic  descending;

    modport source (output valid, output command, output zone,
                    output descending, input ready);
    modport sink   (input valid, input command, input zone,
                    input descending, output ready);
endinterface

// ===== rtl/core/tvzs_cfg_regs.sv =====
// Configuration register file: limits and backlight window.
// Depends on tvzs_pkg.
module tvzs_cfg_regs import tvzs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_we,
    input  t_cfg_idx  i_idx,
    input  t_cfg_data i_wdata,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cold_limit <= RST_COLD_LIMIT;
            r_cfg.hot_limit  <= RST_HOT_LIMIT;
            r_cfg.bl_low     <= RST_BL_LOW;
            r_cfg.bl_high    <= RST_BL_HIGH;
        end else if (i_we) begin
            case (i_idx)
                REG_COLD_LIMIT: r_cfg.cold_limit <= t_temp'(i_wdata);
                REG_HOT_LIMIT:  r_cfg.hot_limit  <= t_temp'(i_wdata);
                REG_BL_LOW:     r_cfg.bl_low     <= i_wdata[BL_W-1:0];
                REG_BL_HIGH:    r_cfg.bl_high    <= i_wdata[BL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/tvzs_zone_core.sv =====
// Zone tracking state and per-sample zone decision.
// Depends on tvzs_pkg.
module tvzs_zone_core import tvzs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic  r_has_run, n_has_run;
    logic  r_falling, n_falling;
    t_zone r_zone,    n_zone;
    t_temp r_lowest,  n_lowest;

    logic  fresh, new_min, in_window, pick;
    logic  cold_hit, mid_hit, hot_hit;
    t_zone zone_base, cmd;
    t_temp temp;

    always_comb begin
        temp      = i_sample.temperature;
        fresh     = !r_has_run || i_sample.panel_off;
        new_min   = r_has_run && ($signed(temp) < $signed(r_lowest));
        in_window = (i_sample.backlight_level >= i_cfg.bl_low) &&
                    (i_sample.backlight_level <  i_cfg.bl_high);

        // min tracking, then power-off override
        n_falling = r_has_run ? new_min : r_falling;
        zone_base = r_zone;
        if (i_sample.panel_off) begin
            n_falling = 1'b0;
            zone_base = ZONE_NONE;
        end

        pick     = fresh || n_falling;
        cold_hit = (zone_base != ZONE_COLD) && in_window &&
                   ($signed(temp) <= $signed(i_cfg.cold_limit));
        mid_hit  = (zone_base != ZONE_MID) && in_window &&
                   ($signed(temp) >  $signed(i_cfg.cold_limit)) &&
                   ($signed(temp) <  $signed(i_cfg.hot_limit));
        hot_hit  = (zone_base != ZONE_HOT) &&
                   ($signed(temp) >= $signed(i_cfg.hot_limit));

        cmd = ZONE_NONE;
        if (pick) begin
            if (cold_hit)      cmd = ZONE_COLD;
            else if (mid_hit)  cmd = ZONE_MID;
            else if (hot_hit)  cmd = ZONE_HOT;
        end

        n_zone    = (cmd != ZONE_NONE) ? cmd : zone_base;
        n_lowest  = (fresh || new_min) ? temp : r_lowest;
        n_has_run = 1'b1;

        o_result.command    = cmd;
        o_result.zone       = n_zone;
        o_result.descending = n_falling;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_run <= 1'b0;
            r_falling <= 1'b0;
            r_zone    <= ZONE_NONE;
            r_lowest  <= '0;
        end else if (i_adv) begin
            r_has_run <= n_has_run;
            r_falling <= n_falling;
            r_zone    <= n_zone;
            r_lowest  <= n_lowest;
        end
    end

endmodule

// ===== rtl/core/thermal_vss_zone_selector_top.sv =====
// Thermal VSS zone selector: usage notes
// Request channel i_req carries temperature (18b signed, millidegrees),
// backlight_level (12b) and panel_off; a request is accepted when valid
// and ready are both high on a rising clock edge.
// Result channel o_rsp carries command (0 none, 1 cold, 2 mid, 3 hot),
// zone after the sample and the descending flag, one result per request.
// Path: a request is captured in the input register, then its result in
// the result register, which drives o_rsp; a stall on o_rsp can hold it
// in the input register. Throughput: one request per cycle while o_rsp.ready
// is high, set by the combinational zone decision that updates the tracking state.
// Stall: when o_rsp.ready is low the result holds; one more request
// may sit in the input register, after which i_req.ready drops.
// Reset (i_rst_n, synchronous, active low): both pipeline stages empty,
// tracking state cleared, limits back to 0 / 10000 and the backlight
// window to 3000..3974. Config is written via i_cfg_we / i_cfg_idx /
// i_cfg_wdata while the block is idle; no read-back.
// Depends on tvzs_pkg, tvzs_ifs, tvzs_cfg_regs, tvzs_zone_core and
// thermal_vss_zone_selector_top_assert.svh.
`include "thermal_vss_zone_selector_top_assert.svh"

module thermal_vss_zone_selector_top import tvzs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tvzs_req_if.sink   i_req,
    tvzs_rsp_if.source o_rsp,
    input  logic       i_cfg_we,
    input  t_cfg_idx   i_cfg_idx,
    input  t_cfg_data  i_cfg_wdata
);

    t_cfg    cfg;
    t_result result;

    // input stage
    logic    r_in_valid;
    t_sample r_in;
    // result stage
    logic    r_out_valid;
    t_result r_out;

    logic adv;       // input stage moves into result stage
    logic in_take;   // request accepted

    // result stage can load when empty or being drained
    assign adv     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || adv;
    assign in_take = i_req.valid && i_req.ready;

    tvzs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    tvzs_zone_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_sample (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.temperature     <= i_req.temperature;
            r_in.backlight_level <= i_req.backlight_level;
            r_in.panel_off       <= i_req.panel_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.command    = r_out.command;
    assign o_rsp.zone       = r_out.zone;
    assign o_rsp.descending = r_out.descending;

    // a sent command always names the zone it moved to
    `TVZS_ASSERT_IMPLY(a_cmd_matches_zone, i_clk, i_rst_n,
        r_out_valid && (r_out.command != ZONE_NONE), r_out.zone == r_out.command)
    // both stages full and sink stalled: no new request taken
    `TVZS_ASSERT_IMPLY(a_full_blocks_req, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !o_rsp.ready, !i_req.ready)
    // every advance yields a valid result next cycle
    `TVZS_ASSERT_NEXT(a_adv_gives_result, i_clk, i_rst_n, adv, r_out_valid)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for thermal_vss_zone_selector_top: directed and random
// temperature samples, a per-sample zone predictor and a result scoreboard.
// Depends on tvzs_pkg, tvzs_ifs and the zone selector RTL.
module testbench;
    import tvzs_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int RST_CYCLES = 10;
    localparam int RUN_LIMIT  = 500000;  // cycles; far above the slowest legal run
    localparam int TAIL       = 6;       // two-stage pipe plus margin

    // receiver ready styles
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    // threshold settings used across phases
    localparam int SET_RESET   = 0;
    localparam int SET_RANGE   = 1;
    localparam int SET_WIDEST  = 2;
    localparam int SET_CROSSED = 3;
    localparam int SET_EMPTY   = 4;
    localparam int SET_ANY     = 5;
    localparam int SET_KINDS   = 6;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      cfg_we;
    t_cfg_idx  cfg_idx;
    t_cfg_data cfg_wdata;

    tvzs_req_if req_if ();
    tvzs_rsp_if rsp_if ();

    thermal_vss_zone_selector_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Zone predictor: own copy of thresholds and tracking state
    // ------------------------------------------------------------------
    t_temp lim_cold;
    t_temp lim_hot;
    t_bl   win_lo;
    t_bl   win_hi;

    logic  seen_sample;
    logic  temp_falling;
    t_zone cur_zone;
    t_temp min_temp;

    t_result zone_results[$];  // expected results, oldest first

    int n_errors;
    int n_samples;
    int n_checked;
    int n_panel_off;
    int n_falling;
    int n_settings;
    int cmd_count[4];

    // One sample in, one result out; updates tracking state as the block does.
    function automatic t_result pick_zone(input t_sample s);
        t_result r;
        t_temp   tv;
        logic    fresh;
        logic    in_win;
        t_zone   cmd;
        tv     = s.temperature;
        fresh  = !seen_sample || s.panel_off;
        in_win = (s.backlight_level >= win_lo) && (s.backlight_level < win_hi);
        cmd    = ZONE_NONE;
        // new minimum only counts once a sample has been seen
        if (seen_sample) begin
            if (min_temp > tv) begin
                temp_falling = 1'b1;
                min_temp     = tv;
            end else begin
                temp_falling = 1'b0;
            end
        end
        if (s.panel_off) begin
            temp_falling = 1'b0;
            cur_zone     = ZONE_NONE;
        end
        // first match wins, even with crossed limits
        if (fresh || temp_falling) begin
            if (cur_zone != ZONE_COLD && tv <= lim_cold && in_win)
                cmd = ZONE_COLD;
            else if (cur_zone != ZONE_MID && tv > lim_cold && tv < lim_hot && in_win)
                cmd = ZONE_MID;
            else if (cur_zone != ZONE_HOT && tv >= lim_hot)
                cmd = ZONE_HOT;
            if (cmd != ZONE_NONE)
                cur_zone = cmd;
        end
        if (fresh)
            min_temp = tv;
        seen_sample  = 1'b1;
        r.command    = cmd;
        r.zone       = cur_zone;
        r.descending = temp_falling;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side: bursts with gaps, driven on the falling edge
    // ------------------------------------------------------------------
    logic bursty;
    int   burst_left;

    // Holds one request until accepted, then books its expected result.
    task automatic send_sample(input t_sample s);
        t_result r;
        @(negedge i_clk);
        req_if.valid           <= 1'b1;
        req_if.temperature     <= s.temperature;
        req_if.backlight_level <= s.backlight_level;
        req_if.panel_off       <= s.panel_off;
        do @(posedge i_clk); while (!req_if.ready);
        r = pick_zone(s);
        zone_results.push_back(r);
        n_samples++;
        cmd_count[r.command]++;
        if (s.panel_off) n_panel_off++;
        if (r.descending) n_falling++;
    endtask

    // Wraps send_sample with random burst lengths and idle gaps.
    task automatic offer_sample(input t_sample s);
        int gap;
        if (bursty) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 24);
                if (gap != 0) begin
                    @(negedge i_clk);
                    req_if.valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
            burst_left--;
        end
        send_sample(s);
    endtask

    // Drop valid, then wait for every booked result plus the pipe depth.
    task automatic settle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (zone_results.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration writes, only while idle
    // ------------------------------------------------------------------
    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            REG_COLD_LIMIT: lim_cold = t_temp'(data);
            REG_HOT_LIMIT:  lim_hot  = t_temp'(data);
            REG_BL_LOW:     win_lo   = data[BL_W-1:0];
            REG_BL_HIGH:    win_hi   = data[BL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_settings(input t_cfg c);
        write_reg(REG_COLD_LIMIT, t_cfg_data'(c.cold_limit));
        write_reg(REG_HOT_LIMIT,  t_cfg_data'(c.hot_limit));
        write_reg(REG_BL_LOW,     t_cfg_data'(c.bl_low));
        write_reg(REG_BL_HIGH,    t_cfg_data'(c.bl_high));
        n_settings++;
    endtask

    function automatic t_cfg make_settings(input int kind);
        t_cfg c;
        t_temp swap_t;
        c.cold_limit = RST_COLD_LIMIT;
        c.hot_limit  = RST_HOT_LIMIT;
        c.bl_low     = RST_BL_LOW;
        c.bl_high    = RST_BL_HIGH;
        case (kind)
            SET_RANGE: begin
                c.cold_limit = t_temp'(int'($urandom_range(0, 165000)) - 40000);
                c.hot_limit  = t_temp'(int'($urandom_range(0, 165000)) - 40000);
                if (c.cold_limit > c.hot_limit) begin
                    swap_t       = c.cold_limit;
                    c.cold_limit = c.hot_limit;
                    c.hot_limit  = swap_t;
                end
                c.bl_low  = t_bl'($urandom_range(0, 2000));
                c.bl_high = t_bl'($urandom_range(2001, 4095));
            end
            SET_WIDEST: begin
                c.cold_limit = {1'b1, {(TEMP_W-1){1'b0}}};
                c.hot_limit  = {1'b0, {(TEMP_W-1){1'b1}}};
                c.bl_low     = '0;
                c.bl_high    = '1;
            end
            SET_CROSSED: begin
                c.cold_limit = t_temp'(int'($urandom_range(20000, 125000)));
                c.hot_limit  = t_temp'(int'($urandom_range(0, 60000)) - 40000);
            end
            SET_EMPTY: begin
                c.bl_low  = t_bl'($urandom_range(2048, 4095));
                c.bl_high = t_bl'($urandom_range(0, 2048));
            end
            SET_ANY: begin
                c.cold_limit = t_temp'($urandom);
                c.hot_limit  = t_temp'($urandom);
                c.bl_low     = t_bl'($urandom);
                c.bl_high    = t_bl'($urandom);
            end
            default: ;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready pattern, long hold-off and the scoreboard
    // ------------------------------------------------------------------
    int rx_style;
    int rx_phase;
    int hold_cycles;  // set by the pressure test, counted down here

    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 1;
        if (hold_cycles > 0) begin
            hold_cycles   <= hold_cycles - 1;
            rsp_if.ready  <= 1'b0;
        end else begin
            case (rx_style)
                RX_RANDOM:  rsp_if.ready <= ($urandom_range(0, 2) != 0);
                RX_PATTERN: rsp_if.ready <= ((rx_phase % 11) < 6);
                default:    rsp_if.ready <= 1'b1;
            endcase
        end
    end

    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (zone_results.size() == 0) begin
                n_errors++;
                $display("%0t: expected no result, got cmd=%0d zone=%0d desc=%0d",
                         $time, rsp_if.command, rsp_if.zone, rsp_if.descending);
            end else begin
                want = zone_results.pop_front();
                n_checked++;
                if (rsp_if.command !== want.command) begin
                    n_errors++;
                    $display("%0t: command expected %0d, got %0d",
                             $time, want.command, rsp_if.command);
                end
                if (rsp_if.zone !== want.zone) begin
                    n_errors++;
                    $display("%0t: zone expected %0d, got %0d",
                             $time, want.zone, rsp_if.zone);
                end
                if (rsp_if.descending !== want.descending) begin
                    n_errors++;
                    $display("%0t: descending expected %0b, got %0b",
                             $time, want.descending, rsp_if.descending);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    int cycle_count;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, zone_results.size());
            $display("** thermal_vss_zone_selector_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_sample mk(input int tv, input int bl, input logic off);
        t_sample s;
        s.temperature     = t_temp'(tv);
        s.backlight_level = t_bl'(bl);
        s.panel_off       = off;
        return s;
    endfunction

    // Backlight near the window edges half of the time.
    function automatic t_bl pick_backlight();
        case ($urandom_range(0, 7))
            0: return win_lo;
            1: return win_lo - 1'b1;
            2: return win_hi;
            3: return win_hi - 1'b1;
            4, 5: return t_bl'($urandom);
            default: begin
                if (win_lo < win_hi)
                    return win_lo + t_bl'($urandom_range(0, int'(win_hi) - int'(win_lo) - 1));
                return t_bl'($urandom);
            end
        endcase
    endfunction

    // A run of samples: start near a limit or at random, then mostly falling so the
    // block re-evaluates its zone; a few rises, repeats and wild values.
    task automatic offer_run(input int len);
        int      walk;
        t_sample s;
        case ($urandom_range(0, 2))
            0:       walk = int'(lim_cold) + int'($urandom_range(0, 6000)) - 1000;
            1:       walk = int'(lim_hot) + int'($urandom_range(0, 6000)) - 1000;
            default: walk = int'($urandom_range(0, 165000)) - 40000;
        endcase
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12:
                    walk = walk - int'($urandom_range(0, 2500));
                13, 14, 15: walk = walk + int'($urandom_range(1, 3000));
                16:         ;
                default:    walk = int'($urandom);
            endcase
            s.temperature     = t_temp'(walk);
            walk              = int'(s.temperature);  // keep the walk in 18-bit range
            s.backlight_level = pick_backlight();
            s.panel_off       = (k == 0) ? ($urandom_range(0, 2) == 0)
                                         : ($urandom_range(0, 39) == 0);
            offer_sample(s);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset thresholds: first sample, falling, window edges, field extremes,
    // power-off clearing the zone.
    task automatic test_reset_thresholds();
        send_sample(mk(5000, 3500, 1'b0));       // first sample lands in mid
        send_sample(mk(4000, 3500, 1'b0));       // falling, already mid: no command
        send_sample(mk(-131072, 3000, 1'b0));    // coldest value, window start
        send_sample(mk(131071, 3974, 1'b0));     // rising: no re-evaluation
        send_sample(mk(131071, 4095, 1'b1));     // power-off, hot regardless of window
        send_sample(mk(-1, 2999, 1'b0));         // just below window
        send_sample(mk(-2, 3975, 1'b0));         // window end is exclusive
        send_sample(mk(9999, 0, 1'b1));          // no zone fits: zone stays unset
        send_sample(mk(10000, 4095, 1'b1));      // hot limit is inclusive
        send_sample(mk(0, 3974, 1'b1));          // cold limit is inclusive
        settle();
    endtask

    // Cold limit above hot limit: cold test wins unless already cold.
    task automatic test_crossed_limits();
        write_settings(make_settings(SET_CROSSED));
        send_sample(mk(int'(lim_hot) + 10, 3500, 1'b1));
        send_sample(mk(int'(lim_hot) + 5, 3500, 1'b0));
        send_sample(mk(int'(lim_hot) + 1, 100, 1'b0));
        send_sample(mk(int'(lim_hot), 3500, 1'b0));
        settle();
    endtask

    // Empty backlight window, then the widest window and limits.
    task automatic test_window_extremes();
        t_cfg c;
        c.cold_limit = {1'b1, {(TEMP_W-1){1'b0}}};
        c.hot_limit  = {1'b0, {(TEMP_W-1){1'b1}}};
        c.bl_low     = 12'd4000;
        c.bl_high    = 12'd100;
        write_settings(c);
        send_sample(mk(-131072, 4000, 1'b1));    // empty window: nothing fits
        send_sample(mk(131071, 50, 1'b1));       // only hot is possible
        settle();
        write_settings(make_settings(SET_WIDEST));
        send_sample(mk(-131072, 0, 1'b1));
        send_sample(mk(0, 4094, 1'b1));
        send_sample(mk(131071, 4095, 1'b1));
        send_sample(mk(-131072, 4095, 1'b0));    // falling, outside the window
        settle();
    endtask

    // Receiver holds off long enough for both stages to fill and the
    // request side to stall; the sender keeps offering back to back.
    task automatic test_backpressure();
        write_settings(make_settings(SET_RESET));
        bursty   = 1'b0;
        rx_style = RX_ALWAYS;
        @(posedge i_clk);
        hold_cycles = 60;
        offer_run(24);
        settle();
    endtask

    // Random runs over rotating threshold settings and idle styles.
    task automatic test_random_runs();
        int left;
        int len;
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            write_settings(make_settings(ph % SET_KINDS));
            bursty     = (ph % 3) != 0;
            burst_left = 0;
            rx_style   = ph % 3;
            left       = 250;
            while (left > 0) begin
                len = $urandom_range(3, 20);
                if (len > left) len = left;
                offer_run(len);
                left -= len;
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_idx                = REG_COLD_LIMIT;
        cfg_wdata              = '0;
        req_if.valid           = 1'b0;
        req_if.temperature     = '0;
        req_if.backlight_level = '0;
        req_if.panel_off       = 1'b0;
        rsp_if.ready           = 1'b0;
        rx_style               = RX_ALWAYS;
        rx_phase               = 0;
        hold_cycles            = 0;
        bursty                 = 1'b0;
        burst_left             = 0;
        cycle_count            = 0;
        n_errors               = 0;
        n_samples              = 0;
        n_checked              = 0;
        n_panel_off            = 0;
        n_falling              = 0;
        n_settings             = 0;
        cmd_count              = '{default: 0};
        // predictor starts from the reset state
        lim_cold     = RST_COLD_LIMIT;
        lim_hot      = RST_HOT_LIMIT;
        win_lo       = RST_BL_LOW;
        win_hi       = RST_BL_HIGH;
        seen_sample  = 1'b0;
        temp_falling = 1'b0;
        cur_zone     = ZONE_NONE;
        min_temp     = '0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_thresholds();
        test_crossed_limits();
        test_window_extremes();
        test_backpressure();
        test_random_runs();

        $display("Covered %0d samples over %0d threshold settings, %0d power-offs, %0d falling.",
                 n_samples, n_settings, n_panel_off, n_falling);
        $display("Checked %0d results: %0d quiet, %0d cold, %0d mid, %0d hot commands.",
                 n_checked, cmd_count[ZONE_NONE], cmd_count[ZONE_COLD],
                 cmd_count[ZONE_MID], cmd_count[ZONE_HOT]);
        if (n_errors == 0 && zone_results.size() == 0) begin
            $display("** thermal_vss_zone_selector_top: PASSED **");
        end else begin
            $display("** thermal_vss_zone_selector_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tvzs_pkg.sv
rtl/core/tvzs_ifs.sv
rtl/core/tvzs_cfg_regs.sv
rtl/core/tvzs_zone_core.sv
rtl/core/thermal_vss_zone_selector_top.sv
tb/testbench.sv
